// ----- hw/rtl/btr_pkg.sv -----
// Shared types, constants and the 5x7 font ROM of the text run rasterizer.
package btr_pkg;

	localparam int FONT_COLS = 5;
	localparam int FONT_ROWS = 7;
	localparam int COORD_W   = 12;
	localparam int ROW_W     = $clog2(FONT_ROWS);
	localparam int COL_W     = $clog2(FONT_COLS + 1);
	localparam int MUL_W     = 3;
	localparam int SCALE_W   = 4;

	localparam logic [MUL_W-1:0]   CELL_MULT = MUL_W'(FONT_COLS + 1);
	localparam logic [MUL_W-1:0]   ROW_MULT  = MUL_W'(1);
	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET = COORD_W'(320);

	typedef logic [FONT_ROWS-1:0][FONT_COLS-1:0] glyph_t;

	typedef struct packed {
		logic               rect_valid;
		logic [COORD_W-1:0] rect_left;
		logic [COORD_W-1:0] rect_top;
		logic [COORD_W-1:0] rect_right;
		logic [COORD_W-1:0] rect_bottom;
		logic [7:0]         rect_color;
		logic               last_of_char;
	} rect_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ROW,
		ST_SCAN,
		ST_LEFT,
		ST_RIGHT,
		ST_EMPTY
	} seq_state_t;

	function automatic glyph_t pk(input logic [4:0] r0, input logic [4:0] r1,
			input logic [4:0] r2, input logic [4:0] r3, input logic [4:0] r4,
			input logic [4:0] r5, input logic [4:0] r6);
		glyph_t g;
		g[0] = r0; g[1] = r1; g[2] = r2; g[3] = r3;
		g[4] = r4; g[5] = r5; g[6] = r6;
		return g;
	endfunction

	// Fold lower case, fall back to the question mark for codes without a glyph.
	function automatic glyph_t glyph_lookup(input logic [7:0] code_in);
		logic [7:0] code;
		glyph_t     g;
		code = code_in;
		if (code >= "a" && code <= "z") begin
			code = code - 8'd32;
		end
		unique case (code)
			" ":  g = pk(5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00);
			"0":  g = pk(5'h0E,5'h13,5'h15,5'h15,5'h15,5'h19,5'h0E);
			"1":  g = pk(5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E);
			"2":  g = pk(5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F);
			"3":  g = pk(5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E);
			"4":  g = pk(5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02);
			"5":  g = pk(5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E);
			"6":  g = pk(5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E);
			"7":  g = pk(5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08);
			"8":  g = pk(5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E);
			"9":  g = pk(5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C);
			"A":  g = pk(5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11);
			"B":  g = pk(5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E);
			"C":  g = pk(5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F);
			"D":  g = pk(5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E);
			"E":  g = pk(5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F);
			"F":  g = pk(5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10);
			"G":  g = pk(5'h0F,5'h10,5'h10,5'h13,5'h11,5'h11,5'h0F);
			"H":  g = pk(5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11);
			"I":  g = pk(5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E);
			"J":  g = pk(5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C);
			"K":  g = pk(5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11);
			"L":  g = pk(5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F);
			"M":  g = pk(5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11);
			"N":  g = pk(5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11);
			"O":  g = pk(5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E);
			"P":  g = pk(5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10);
			"Q":  g = pk(5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D);
			"R":  g = pk(5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11);
			"S":  g = pk(5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E);
			"T":  g = pk(5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04);
			"U":  g = pk(5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E);
			"V":  g = pk(5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04);
			"W":  g = pk(5'h11,5'h11,5'h11,5'h11,5'h15,5'h1B,5'h11);
			"X":  g = pk(5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11);
			"Y":  g = pk(5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04);
			"Z":  g = pk(5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F);
			".":  g = pk(5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C);
			",":  g = pk(5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h08);
			"!":  g = pk(5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04);
			":":  g = pk(5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00);
			";":  g = pk(5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h08);
			"-":  g = pk(5'h00,5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00);
			"_":  g = pk(5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F);
			"'":  g = pk(5'h04,5'h04,5'h04,5'h00,5'h00,5'h00,5'h00);
			"\"": g = pk(5'h0A,5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00);
			"/":  g = pk(5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10);
			"(":  g = pk(5'h06,5'h08,5'h08,5'h08,5'h08,5'h08,5'h06);
			")":  g = pk(5'h0C,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0C);
			"[":  g = pk(5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E);
			"]":  g = pk(5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E);
			"=":  g = pk(5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00);
			"+":  g = pk(5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00);
			">":  g = pk(5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10);
			"<":  g = pk(5'h01,5'h02,5'h04,5'h08,5'h04,5'h02,5'h01);
			"*":  g = pk(5'h00,5'h11,5'h0E,5'h1F,5'h0E,5'h11,5'h00);
			default: g = pk(5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04);
		endcase
		return g;
	endfunction

endpackage

// ----- hw/rtl/btr_madd.sv -----
// Shared multiply-add unit: y = a + m * k over small factors.
module btr_madd (
	input  logic [btr_pkg::COORD_W-1:0]               a,
	input  logic [btr_pkg::MUL_W-1:0]                 m,
	input  logic [btr_pkg::SCALE_W-1:0]               k,
	output logic [btr_pkg::COORD_W:0]                 y
);

	localparam int PROD_W = btr_pkg::MUL_W + btr_pkg::SCALE_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(m) * PROD_W'(k);
	assign y    = {1'b0, a} + (btr_pkg::COORD_W + 1)'(prod);

endmodule

// ----- hw/rtl/btr_seq.sv -----
// Sequencer: clip test, row and run scan, and rectangle corners on the shared unit.
module btr_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      char_code,
	input  logic                            first_of_string,
	input  logic [10:0]                     origin_x,
	input  logic [10:0]                     origin_y,
	input  logic [7:0]                      color_index,
	input  logic [btr_pkg::SCALE_W-1:0]     scale_factor,
	input  logic [btr_pkg::COORD_W-1:0]     clip_limit_q,
	input  logic                            out_free,
	output logic                            push,
	output btr_pkg::rect_t                  rect
);

	localparam int CW = btr_pkg::COORD_W;

	btr_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]                    pen_q, base_q, top_q, bot_q, left_q;
	logic                             clipped_q;
	btr_pkg::glyph_t                  glyph_q;
	logic [10:0]                      oy_q;
	logic [7:0]                       color_q;
	logic [btr_pkg::SCALE_W-1:0]      scale_q;
	logic [btr_pkg::ROW_W-1:0]        row_q, last_row;
	logic [btr_pkg::COL_W-1:0]        col_q, start_q, len_q;
	logic                             last_q;

	logic [CW-1:0]                    madd_a;
	logic [btr_pkg::MUL_W-1:0]        madd_m;
	logic [CW:0]                      madd_y;

	logic                             accept, glyph_lit, clip_hit;
	logic [btr_pkg::FONT_COLS-1:0]    dots;
	logic                             run_found, more_after;
	logic [btr_pkg::COL_W-1:0]        span_lo, run_end;

	btr_madd u_madd (
		.a (madd_a),
		.m (madd_m),
		.k (scale_q),
		.y (madd_y)
	);

	assign accept    = in_valid && in_ready;
	assign glyph_lit = |glyph_q;
	assign clip_hit  = madd_y > {1'b0, clip_limit_q};

	always_comb begin
		last_row = '0;
		for (int r = 0; r < btr_pkg::FONT_ROWS; r++) begin
			if (glyph_q[r] != '0) begin
				last_row = btr_pkg::ROW_W'(r);
			end
		end
	end

	// Find the next run of lit dots at or right of col_q; column 0 is the MSB.
	always_comb begin
		logic done;
		done       = 1'b0;
		run_found  = 1'b0;
		span_lo    = '0;
		run_end    = btr_pkg::COL_W'(btr_pkg::FONT_COLS);
		more_after = 1'b0;
		for (int c = 0; c < btr_pkg::FONT_COLS; c++) begin
			dots[c] = glyph_q[row_q][btr_pkg::FONT_COLS-1-c];
		end
		for (int c = 0; c < btr_pkg::FONT_COLS; c++) begin
			if (!run_found && c >= int'(col_q) && dots[c]) begin
				run_found = 1'b1;
				span_lo   = btr_pkg::COL_W'(c);
			end
		end
		for (int c = 0; c < btr_pkg::FONT_COLS; c++) begin
			if (run_found && !done && c > int'(span_lo) && !dots[c]) begin
				run_end = btr_pkg::COL_W'(c);
				done    = 1'b1;
			end
		end
		for (int c = 0; c < btr_pkg::FONT_COLS; c++) begin
			if (c > int'(run_end) && dots[c]) begin
				more_after = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btr_pkg::ST_IDLE: begin
				if (accept) state_d = btr_pkg::ST_CHECK;
			end
			btr_pkg::ST_CHECK: begin
				if (scale_q == '0 || clipped_q || clip_hit || !glyph_lit) begin
					state_d = btr_pkg::ST_EMPTY;
				end else begin
					state_d = btr_pkg::ST_ROW;
				end
			end
			btr_pkg::ST_ROW: state_d = btr_pkg::ST_SCAN;
			btr_pkg::ST_SCAN: begin
				priority if (run_found) begin
					state_d = btr_pkg::ST_LEFT;
				end else if (row_q == btr_pkg::ROW_W'(btr_pkg::FONT_ROWS - 1)) begin
					state_d = btr_pkg::ST_IDLE;
				end else begin
					state_d = btr_pkg::ST_ROW;
				end
			end
			btr_pkg::ST_LEFT: state_d = btr_pkg::ST_RIGHT;
			btr_pkg::ST_RIGHT: begin
				if (out_free) state_d = last_q ? btr_pkg::ST_IDLE : btr_pkg::ST_SCAN;
			end
			btr_pkg::ST_EMPTY: begin
				if (out_free) state_d = btr_pkg::ST_IDLE;
			end
			default: state_d = btr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		madd_a   = pen_q;
		madd_m   = btr_pkg::CELL_MULT;
		rect     = '0;
		rect.last_of_char = 1'b1;
		unique case (state_q)
			btr_pkg::ST_IDLE:  in_ready = 1'b1;
			btr_pkg::ST_CHECK: begin
				madd_a = pen_q;
				madd_m = btr_pkg::CELL_MULT;
			end
			btr_pkg::ST_ROW: begin
				madd_a = top_q;
				madd_m = btr_pkg::ROW_MULT;
			end
			btr_pkg::ST_SCAN: begin
			end
			btr_pkg::ST_LEFT: begin
				madd_a = base_q;
				madd_m = start_q;
			end
			btr_pkg::ST_RIGHT: begin
				madd_a            = left_q;
				madd_m            = len_q;
				push              = out_free;
				rect.rect_valid   = 1'b1;
				rect.rect_left    = left_q;
				rect.rect_top     = top_q;
				rect.rect_right   = madd_y[CW-1:0];
				rect.rect_bottom  = bot_q;
				rect.rect_color   = color_q;
				rect.last_of_char = last_q;
			end
			btr_pkg::ST_EMPTY: push = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= btr_pkg::ST_IDLE;
			pen_q     <= '0;
			clipped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && first_of_string) begin
				pen_q     <= CW'(origin_x);
				clipped_q <= 1'b0;
			end
			if (state_q == btr_pkg::ST_CHECK && scale_q != '0 && !clipped_q) begin
				// Drop the cell and the rest of the string, or advance the pen.
				if (clip_hit) clipped_q <= 1'b1;
				else pen_q <= madd_y[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_q <= btr_pkg::glyph_lookup(char_code);
			oy_q    <= origin_y;
			color_q <= color_index;
			scale_q <= scale_factor;
		end
		unique case (state_q)
			btr_pkg::ST_CHECK: begin
				base_q <= pen_q;
				top_q  <= CW'(oy_q);
				row_q  <= '0;
			end
			btr_pkg::ST_ROW: begin
				bot_q <= madd_y[CW-1:0];
				col_q <= '0;
			end
			btr_pkg::ST_SCAN: begin
				if (run_found) begin
					start_q <= span_lo;
					len_q   <= run_end - span_lo;
					last_q  <= (row_q == last_row) && !more_after;
				end else begin
					top_q <= bot_q;
					row_q <= row_q + 1'b1;
				end
			end
			btr_pkg::ST_LEFT: left_q <= madd_y[CW-1:0];
			btr_pkg::ST_RIGHT: begin
				if (out_free) col_q <= start_q + len_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/bitmap_text_run_rasterizer.sv -----
// Top level of the 5x7 text run rasterizer: config register, sequencer, output register.
// Flow: clip check, then a scan row by row; each run of lit dots gets its left corner,
// then its right corner and the output word, at most one multiply-add per cycle on the
// shared unit; a full output register stalls the sequencer. A blank, clipped or zero-scale
// character gives one empty word. A new character is taken only once its last word is pushed.
// Reset: pen at 0, clip flag clear, screen width 320, output register empty.
module bitmap_text_run_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] clip_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        first_of_string,
	input  logic [10:0] origin_x,
	input  logic [10:0] origin_y,
	input  logic [7:0]  color_index,
	input  logic [3:0]  scale_factor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rect_valid,
	output logic [11:0] rect_left,
	output logic [11:0] rect_top,
	output logic [11:0] rect_right,
	output logic [11:0] rect_bottom,
	output logic [7:0]  rect_color,
	output logic        last_of_char
);

	logic [11:0]    clip_limit_q;
	logic           out_valid_q, out_free, push;
	btr_pkg::rect_t rect, rect_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	btr_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.char_code       (char_code),
		.first_of_string (first_of_string),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.color_index     (color_index),
		.scale_factor    (scale_factor),
		.clip_limit_q    (clip_limit_q),
		.out_free        (out_free),
		.push            (push),
		.rect            (rect)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_limit_q <= btr_pkg::SCREEN_WIDTH_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) clip_limit_q <= clip_limit;
			if (push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) rect_q <= rect;
	end

	assign out_valid    = out_valid_q;
	assign rect_valid   = rect_q.rect_valid;
	assign rect_left    = rect_q.rect_left;
	assign rect_top     = rect_q.rect_top;
	assign rect_right   = rect_q.rect_right;
	assign rect_bottom  = rect_q.rect_bottom;
	assign rect_color   = rect_q.rect_color;
	assign last_of_char = rect_q.last_of_char;

endmodule

// ----- hw/rtl/btr_checker.sv -----
// Port-level checks for the text run rasterizer, bound to the top level.
module btr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        rect_valid,
	input logic [11:0] rect_left,
	input logic [11:0] rect_top,
	input logic [11:0] rect_right,
	input logic [11:0] rect_bottom,
	input logic [7:0]  rect_color,
	input logic        last_of_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rect_valid) && $stable(rect_left)
			&& $stable(rect_right) && $stable(rect_top) && $stable(rect_bottom)
			&& $stable(rect_color) && $stable(last_of_char))
		else $error("output word changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new character taken while one is in work");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rect_valid |-> last_of_char)
		else $error("empty word not marked last");

	a_rect_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rect_valid |-> rect_right != rect_left && rect_bottom != rect_top)
		else $error("rectangle has zero size");

endmodule

bind bitmap_text_run_rasterizer btr_checker u_btr_checker (.*);

// ----- bench/glyph_rect_checker.sv -----
// Checker for the text run rasterizer: predicts rectangles per character and compares each word.
module glyph_rect_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [11:0] clip_limit,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        first_of_string,
	input  logic [10:0] origin_x,
	input  logic [10:0] origin_y,
	input  logic [7:0]  color_index,
	input  logic [3:0]  scale_factor,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        rect_valid,
	input  logic [11:0] rect_left,
	input  logic [11:0] rect_top,
	input  logic [11:0] rect_right,
	input  logic [11:0] rect_bottom,
	input  logic [7:0]  rect_color,
	input  logic        last_of_char,
	output int          fail_count,
	output int          pending,
	output int          chars_taken,
	output int          words_checked
);

	localparam logic [11:0] WIDTH_AT_RESET = 12'd320;

	logic [11:0]    clip_edge;
	logic [11:0]    pen;
	logic           clip_flag;
	btr_pkg::rect_t rect_q[$];

	// Row 0 sits in the top five bits, leftmost dot is the MSB of each row.
	function automatic logic [34:0] font_bitmap(input logic [7:0] c);
		case (c)
			"0":  return {5'h0E,5'h13,5'h15,5'h15,5'h15,5'h19,5'h0E};
			"1":  return {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
			"2":  return {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
			"3":  return {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
			"4":  return {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
			"5":  return {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
			"6":  return {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
			"7":  return {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			"8":  return {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
			"9":  return {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
			"A":  return {5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11};
			"B":  return {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
			"C":  return {5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F};
			"D":  return {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
			"E":  return {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
			"F":  return {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
			"G":  return {5'h0F,5'h10,5'h10,5'h13,5'h11,5'h11,5'h0F};
			"H":  return {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			"I":  return {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
			"J":  return {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
			"K":  return {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			"L":  return {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
			"M":  return {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11};
			"N":  return {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			"O":  return {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			"P":  return {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
			"Q":  return {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
			"R":  return {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
			"S":  return {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
			"T":  return {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			"U":  return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			"V":  return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
			"W":  return {5'h11,5'h11,5'h11,5'h11,5'h15,5'h1B,5'h11};
			"X":  return {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
			"Y":  return {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
			"Z":  return {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
			".":  return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C};
			",":  return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h08};
			"!":  return {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
			":":  return {5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00};
			";":  return {5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h08};
			"-":  return {5'h00,5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00};
			"_":  return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F};
			"'":  return {5'h04,5'h04,5'h04,5'h00,5'h00,5'h00,5'h00};
			"\"": return {5'h0A,5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00};
			"/":  return {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10};
			"(":  return {5'h06,5'h08,5'h08,5'h08,5'h08,5'h08,5'h06};
			")":  return {5'h0C,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0C};
			"[":  return {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E};
			"]":  return {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E};
			"=":  return {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00};
			"+":  return {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
			">":  return {5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10};
			"<":  return {5'h01,5'h02,5'h04,5'h08,5'h04,5'h02,5'h01};
			"*":  return {5'h00,5'h11,5'h0E,5'h1F,5'h0E,5'h11,5'h00};
			// question mark, also drawn for every code without a glyph
			default: return {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04};
		endcase
	endfunction

	// Queue the rectangles one character produces and move the pen.
	task automatic rasterize(input logic [7:0] code, input logic first, input logic [10:0] ox,
			input logic [10:0] oy, input logic [7:0] color, input logic [3:0] scale);
		logic [34:0]    bmp;
		logic [4:0]     bits;
		logic [7:0]     folded;
		logic           drop;
		int             sc, adv, row, col, start, n, left, top;
		btr_pkg::rect_t r;
		n    = 0;
		drop = 1'b0;
		sc   = int'(scale);
		adv  = 6 * sc;
		if (first) begin
			pen       = {1'b0, ox};
			clip_flag = 1'b0;
		end
		if (sc == 0 || clip_flag) begin
			drop = 1'b1;
		end else if (int'(pen) + adv > int'(clip_edge)) begin
			clip_flag = 1'b1;
			drop      = 1'b1;
		end
		if (!drop) begin
			if (code != " ") begin
				folded = (code >= "a" && code <= "z") ? code - 8'd32 : code;
				bmp    = font_bitmap(folded);
				for (row = 0; row < 7; row++) begin
					bits = bmp[34 - 5 * row -: 5];
					col  = 0;
					while (col < 5) begin
						if (!bits[4 - col]) begin
							col++;
						end else begin
							start = col;
							while (col < 5 && bits[4 - col]) col++;
							left = int'(pen) + start * sc;
							top  = int'(oy) + row * sc;
							r.rect_valid   = 1'b1;
							r.rect_left    = 12'(left);
							r.rect_top     = 12'(top);
							r.rect_right   = 12'(left + (col - start) * sc);
							r.rect_bottom  = 12'(top + sc);
							r.rect_color   = color;
							r.last_of_char = 1'b0;
							rect_q.push_back(r);
							n++;
						end
					end
				end
			end
			pen = 12'(int'(pen) + adv);
		end
		if (n == 0) begin
			r = '0;
			r.last_of_char = 1'b1;
			rect_q.push_back(r);
		end else begin
			r = rect_q.pop_back();
			r.last_of_char = 1'b1;
			rect_q.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		btr_pkg::rect_t want;
		if (!arst_n) begin
			clip_edge     = WIDTH_AT_RESET;
			pen           = '0;
			clip_flag     = 1'b0;
			fail_count    = 0;
			chars_taken   = 0;
			words_checked = 0;
			rect_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				clip_edge = clip_limit;
			end
			if (in_valid && in_ready) begin
				chars_taken++;
				rasterize(char_code, first_of_string, origin_x, origin_y, color_index,
					scale_factor);
			end
			if (out_valid && out_ready) begin
				words_checked++;
				if (rect_q.size() == 0) begin
					$error("word with nothing expected: valid %0d left %0d top %0d",
						rect_valid, rect_left, rect_top);
					fail_count++;
				end else begin
					want = rect_q.pop_front();
					check_field("rect_valid", 12'(want.rect_valid), 12'(rect_valid));
					check_field("rect_left", want.rect_left, rect_left);
					check_field("rect_top", want.rect_top, rect_top);
					check_field("rect_right", want.rect_right, rect_right);
					check_field("rect_bottom", want.rect_bottom, rect_bottom);
					check_field("rect_color", 12'(want.rect_color), 12'(rect_color));
					check_field("last_of_char", 12'(want.last_of_char), 12'(last_of_char));
				end
			end
		end
		pending = rect_q.size();
	end

endmodule

// ----- bench/tb_bitmap_text_run_rasterizer.sv -----
// Top of the text run rasterizer bench: clock, reset, character stimulus and the verdict.
module tb_bitmap_text_run_rasterizer;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic [11:0] clip_limit      = '0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code       = '0;
	logic        first_of_string = 1'b0;
	logic [10:0] origin_x        = '0;
	logic [10:0] origin_y        = '0;
	logic [7:0]  color_index     = '0;
	logic [3:0]  scale_factor    = '0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic        rect_valid;
	logic [11:0] rect_left;
	logic [11:0] rect_top;
	logic [11:0] rect_right;
	logic [11:0] rect_bottom;
	logic [7:0]  rect_color;
	logic        last_of_char;

	int fail_count;
	int pending;
	int chars_taken;
	int words_checked;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int widths_used   = 0;

	bitmap_text_run_rasterizer dut (.*);

	glyph_rect_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout: stimulus or output words stuck");
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_FULL:        begin send_idle_pct = 0;  stall_pct = 0;  end
			PACE_SEND_GAPS:   begin send_idle_pct = 52; stall_pct = 0;  end
			PACE_RECV_STALLS: begin send_idle_pct = 0;  stall_pct = 52; end
			PACE_BOTH:        begin send_idle_pct = 15; stall_pct = 15; end
		endcase
	endtask

	// Drop valid, then hold until every expected word has been taken.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_width(input logic [11:0] w);
		wait_drain();
		cfg_valid  <= 1'b1;
		clip_limit <= w;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		widths_used++;
	endtask

	task automatic send_char(input logic [7:0] c, input logic f, input logic [10:0] ox,
			input logic [10:0] oy, input logic [7:0] col, input logic [3:0] sc);
		// Idle the sender cycle by cycle before raising valid.
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		char_code       <= c;
		first_of_string <= f;
		origin_x        <= ox;
		origin_y        <= oy;
		color_index     <= col;
		scale_factor    <= sc;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_code();
		string glyphs;
		glyphs = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ.,!?:;-_'\"/()[]=+><*";
		case ($urandom_range(0, 9))
			0:       return 8'($urandom);
			1, 2:    return 8'($urandom_range("a", "z"));
			default: return glyphs[$urandom_range(0, glyphs.len() - 1)];
		endcase
	endfunction

	// Mostly well-formed strings; a few start without the first-of-string flag to chain the pen.
	task automatic send_string(inout int sent);
		int          len, k;
		logic [10:0] ox, oy;
		logic [7:0]  col;
		logic [3:0]  sc;
		len = $urandom_range(1, 8);
		ox  = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 200));
		oy  = 11'($urandom);
		col = 8'($urandom);
		sc  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) sc = 4'($urandom);
			send_char(pick_code(), k == 0 && $urandom_range(0, 9) != 0,
				(k == 0) ? ox : 11'($urandom), oy, col, sc);
			sent++;
		end
	endtask

	initial begin
		pace_t       p;
		int          sent;
		logic [11:0] phase_width[4];
		phase_width = '{12'd2048, 12'd320, 12'd4095, 12'($urandom_range(1, 2048))};
		set_pace(PACE_FULL);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Screen width still at its reset value.
		send_char("A", 1'b0, 11'd1234, 11'd5, 8'h11, 4'd1);
		send_char("H", 1'b1, 11'd0, 11'd0, 8'h00, 4'd1);
		send_char("a", 1'b0, 11'd77, 11'd20, 8'h5A, 4'd2);
		send_char("z", 1'b0, 11'd0, 11'd20, 8'h5A, 4'd2);
		send_char(8'h00, 1'b0, 11'd0, 11'd40, 8'h3C, 4'd1);
		send_char(8'hFF, 1'b0, 11'd2047, 11'd40, 8'hC3, 4'd1);
		send_char(" ", 1'b0, 11'd0, 11'd40, 8'h01, 4'd2);
		send_char("W", 1'b0, 11'd0, 11'd40, 8'h01, 4'd0);
		send_char("*", 1'b0, 11'd0, 11'd60, 8'hFF, 4'd3);
		// Fill up to the right edge, then the string stays clipped.
		send_char("8", 1'b1, 11'd300, 11'd100, 8'hA5, 4'd3);
		send_char("1", 1'b0, 11'd0, 11'd100, 8'hA5, 4'd3);
		send_char("1", 1'b0, 11'd0, 11'd100, 8'hA5, 4'd1);
		send_char(" ", 1'b1, 11'd310, 11'd100, 8'h0F, 4'd2);
		send_char("?", 1'b0, 11'd0, 11'd100, 8'h0F, 4'd1);
		send_char("!", 1'b1, 11'd314, 11'd0, 8'h80, 4'd1);

		write_width(12'd4095);
		send_char("M", 1'b1, 11'd2047, 11'd2047, 8'hFF, 4'd15);
		send_char("0", 1'b0, 11'd0, 11'd2047, 8'hFF, 4'd15);
		send_char("q", 1'b0, 11'd0, 11'd2047, 8'h7E, 4'd15);

		write_width(12'd0);
		send_char("B", 1'b1, 11'd0, 11'd0, 8'h22, 4'd1);
		send_char(" ", 1'b1, 11'd0, 11'd0, 8'h22, 4'd1);

		write_width(12'd1);
		send_char(".", 1'b1, 11'd0, 11'd0, 8'h44, 4'd1);
		send_char("-", 1'b0, 11'd0, 11'd0, 8'h44, 4'd1);

		for (int i = 0; i < 4; i++) begin
			p = pace_t'(i);
			write_width(phase_width[i]);
			set_pace(p);
			sent = 0;
			while (sent < 48) send_string(sent);
			set_pace(PACE_FULL);
		end

		wait_drain();
		repeat (20) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d characters, %0d output words checked, %0d screen widths written.",
			chars_taken, words_checked, widths_used);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- bitmap_text_run_rasterizer.f -----
hw/rtl/btr_pkg.sv
hw/rtl/btr_madd.sv
hw/rtl/btr_seq.sv
hw/rtl/bitmap_text_run_rasterizer.sv
hw/rtl/btr_checker.sv
bench/glyph_rect_checker.sv
bench/tb_bitmap_text_run_rasterizer.sv
